>>> hdl/aecp_pkg.sv
package aecp_pkg;

    localparam int CoordBits = 12;
    localparam int ParamBits = 16;
    localparam int RgbBits   = 24;

    typedef logic [CoordBits-1:0] coord_t;
    typedef logic [ParamBits-1:0] param_t;
    typedef logic [RgbBits-1:0]   rgb_t;

    localparam coord_t CoordMax  = '1;
    localparam param_t ParamMax  = 16'hFFFF;
    localparam rgb_t   RgbWhite  = 24'hFFFFFF;
    localparam rgb_t   RgbBlack  = 24'h000000;

    // console characters
    localparam logic [7:0] CharEsc    = 8'h1B;
    localparam logic [7:0] CharLbrack = 8'h5B;
    localparam logic [7:0] CharSave   = 8'h37;
    localparam logic [7:0] CharRest   = 8'h38;
    localparam logic [7:0] CharSemi   = 8'h3B;
    localparam logic [7:0] CharZero   = 8'h30;
    localparam logic [7:0] CharNine   = 8'h39;
    localparam logic [7:0] CharUpH    = 8'h48;
    localparam logic [7:0] CharLowF   = 8'h66;
    localparam logic [7:0] CharUpA    = 8'h41;
    localparam logic [7:0] CharUpB    = 8'h42;
    localparam logic [7:0] CharUpC    = 8'h43;
    localparam logic [7:0] CharUpD    = 8'h44;
    localparam logic [7:0] CharUpJ    = 8'h4A;
    localparam logic [7:0] CharUpK    = 8'h4B;
    localparam logic [7:0] CharLowM   = 8'h6D;

    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_ESC    = 2'd1,
        PH_CSI    = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        TOK_PLAIN   = 3'd0,
        TOK_SAVE    = 3'd1,
        TOK_RESTORE = 3'd2,
        TOK_PARAM   = 3'd3,
        TOK_FINAL   = 3'd4
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t kind;
        logic [7:0] code;
        param_t     value;
        coord_t     cx;
        coord_t     cy;
    } token_t;

    typedef enum logic [2:0] {
        ACT_DRAW        = 3'd0,
        ACT_MOVE        = 3'd1,
        ACT_ERASE_BELOW = 3'd2,
        ACT_CLEAR       = 3'd3,
        ACT_ERASE_LINE  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        EL_TO_END   = 2'd0,
        EL_TO_START = 2'd1,
        EL_WHOLE    = 2'd2
    } erase_mode_t;

    typedef enum logic [1:0] {
        BK_IDLE   = 2'd0,
        BK_OPER   = 2'd1,
        BK_SGR    = 2'd2,
        BK_RESULT = 2'd3
    } back_state_t;

    // queue side signals between front and back
    typedef struct packed {
        logic   push;
        token_t tok;
    } q_wr_t;

    function automatic rgb_t palette_rgb(input logic [3:0] idx);
        rgb_t c;
        unique case (idx)
            4'd0:  c = 24'h000000;
            4'd1:  c = 24'hAA0000;
            4'd2:  c = 24'h00AA00;
            4'd3:  c = 24'hAA5500;
            4'd4:  c = 24'h0000AA;
            4'd5:  c = 24'hAA00AA;
            4'd6:  c = 24'h00AAAA;
            4'd7:  c = 24'hAAAAAA;
            4'd8:  c = 24'h555555;
            4'd9:  c = 24'hFF5555;
            4'd10: c = 24'h55FF55;
            4'd11: c = 24'hFFFF55;
            4'd12: c = 24'h5555FF;
            4'd13: c = 24'hFF55FF;
            4'd14: c = 24'h55FFFF;
            4'd15: c = 24'hFFFFFF;
        endcase
        return c;
    endfunction

endpackage

>>> hdl/ansi_escape_console_parser_unit.sv
// Console byte parser: VT100/ANSI escape and CSI sequences to drawing requests.
// Input channel (s_): one console byte per request, with the current pixel
// cursor. Output channel (m_): at most one drawing request per input byte:
// draw char, move cursor, erase below, clear screen or erase line, always
// with the current colors and reverse flag.
// A tokenizer takes bytes at one per cycle, while the queue has room, into a
// two-entry queue; the executor behind it drains one token per cycle for
// plain text while its output slot is free. Plain bytes and cursor restores
// pass through the queue and then the output register. A CSI final byte
// goes through token pop, parameter read and scaling, and result; an SGR
// final instead has the executor walk the parameter store one entry per cycle.
// Sustained rate is one byte per cycle for text while the receiver takes each
// request, lower while CSI sequences execute; s_ready drops when the queue is full.
// Reset (aresetn low, synchronous): parser back to normal text, parameters
// cleared, white on black, reverse off, saved cursor at 0, no result pending.
// When the receiver stalls, the output register holds its request and the
// queue absorbs up to two more tokens before s_ready falls.
module ansi_escape_console_parser_unit #(
    parameter int MAX_PARAMS  = 8,
    parameter int CELL_PIXELS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    input  logic [11:0] s_cursor_x,
    input  logic [11:0] s_cursor_y,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_action,
    output logic [7:0]  m_glyph_code,
    output logic [23:0] m_fg_color,
    output logic [23:0] m_bg_color,
    output logic        m_reverse_on,
    output logic [11:0] m_new_x,
    output logic [11:0] m_new_y,
    output logic [1:0]  m_erase_mode
);

    aecp_pkg::q_wr_t  q_wr;
    aecp_pkg::token_t head;
    logic             q_full, q_empty, q_pop;

    assign s_ready = !q_full;

    aecp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (s_valid && s_ready),
        .byte_in  (s_byte_in),
        .cursor_x (s_cursor_x),
        .cursor_y (s_cursor_y),
        .q_wr     (q_wr)
    );

    aecp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_wr    (q_wr),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .head    (head)
    );

    aecp_back #(
        .MAX_PARAMS  (MAX_PARAMS),
        .CELL_PIXELS (CELL_PIXELS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .empty        (q_empty),
        .head         (head),
        .pop          (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_action     (m_action),
        .m_glyph_code (m_glyph_code),
        .m_fg_color   (m_fg_color),
        .m_bg_color   (m_bg_color),
        .m_reverse_on (m_reverse_on),
        .m_new_x      (m_new_x),
        .m_new_y      (m_new_y),
        .m_erase_mode (m_erase_mode)
    );

endmodule

>>> hdl/aecp_front.sv
module aecp_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic [7:0]           byte_in,
    input  aecp_pkg::coord_t     cursor_x,
    input  aecp_pkg::coord_t     cursor_y,
    output aecp_pkg::q_wr_t      q_wr
);

    aecp_pkg::phase_t phase_reg, phase_next;
    aecp_pkg::param_t accum_reg, accum_next;

    logic        is_digit;
    logic [19:0] acc_prod;

    assign is_digit = (byte_in >= aecp_pkg::CharZero) && (byte_in <= aecp_pkg::CharNine);
    // accum * 10 + digit, saturated below
    assign acc_prod = 20'(accum_reg) * 20'd10 + 20'(byte_in - aecp_pkg::CharZero);

    always_comb begin
        phase_next     = phase_reg;
        accum_next     = accum_reg;
        q_wr.push      = 1'b0;
        q_wr.tok.kind  = aecp_pkg::TOK_PLAIN;
        q_wr.tok.code  = byte_in;
        q_wr.tok.value = accum_reg;
        q_wr.tok.cx    = cursor_x;
        q_wr.tok.cy    = cursor_y;
        if (accept) begin
            unique case (phase_reg)
                aecp_pkg::PH_ESC: begin
                    phase_next = aecp_pkg::PH_NORMAL;
                    if (byte_in == aecp_pkg::CharLbrack) begin
                        phase_next = aecp_pkg::PH_CSI;
                    end else if (byte_in == aecp_pkg::CharSave) begin
                        q_wr.push     = 1'b1;
                        q_wr.tok.kind = aecp_pkg::TOK_SAVE;
                    end else if (byte_in == aecp_pkg::CharRest) begin
                        q_wr.push     = 1'b1;
                        q_wr.tok.kind = aecp_pkg::TOK_RESTORE;
                    end
                end
                aecp_pkg::PH_CSI: begin
                    if (is_digit) begin
                        accum_next = (acc_prod > 20'(aecp_pkg::ParamMax)) ?
                                     aecp_pkg::ParamMax : acc_prod[15:0];
                    end else if (byte_in == aecp_pkg::CharSemi) begin
                        q_wr.push     = 1'b1;
                        q_wr.tok.kind = aecp_pkg::TOK_PARAM;
                        accum_next    = '0;
                    end else begin
                        // final byte carries the pending parameter with it
                        q_wr.push     = 1'b1;
                        q_wr.tok.kind = aecp_pkg::TOK_FINAL;
                        accum_next    = '0;
                        phase_next    = aecp_pkg::PH_NORMAL;
                    end
                end
                default: begin
                    if (byte_in == aecp_pkg::CharEsc) begin
                        phase_next = aecp_pkg::PH_ESC;
                    end else begin
                        q_wr.push = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= aecp_pkg::PH_NORMAL;
            accum_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
        end
    end

endmodule

>>> hdl/aecp_queue.sv
module aecp_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  aecp_pkg::q_wr_t   q_wr,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output aecp_pkg::token_t  head
);

    aecp_pkg::token_t mem [2];

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign head    = mem[rd_ptr_reg];
    assign do_push = q_wr.push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= q_wr.tok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> hdl/aecp_back.sv
module aecp_back #(
    parameter int MAX_PARAMS  = 8,
    parameter int CELL_PIXELS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              empty,
    input  aecp_pkg::token_t  head,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_action,
    output logic [7:0]        m_glyph_code,
    output logic [23:0]       m_fg_color,
    output logic [23:0]       m_bg_color,
    output logic              m_reverse_on,
    output logic [11:0]       m_new_x,
    output logic [11:0]       m_new_y,
    output logic [1:0]        m_erase_mode
);

    localparam int CntW  = $clog2(MAX_PARAMS + 1);
    localparam int IdxW  = $clog2(MAX_PARAMS);
    localparam int StepW = aecp_pkg::ParamBits + $clog2(CELL_PIXELS + 1);

    typedef logic [StepW:0] wide_t;

    function automatic aecp_pkg::coord_t clamp_c(input wide_t v);
        return (v > wide_t'(aecp_pkg::CoordMax)) ? aecp_pkg::CoordMax :
               v[aecp_pkg::CoordBits-1:0];
    endfunction

    aecp_pkg::back_state_t state_reg, state_next;

    aecp_pkg::param_t store_reg [MAX_PARAMS];
    logic             store_we;

    logic [CntW-1:0]  count_reg, count_next;
    logic [IdxW-1:0]  idx_reg, idx_next;

    aecp_pkg::rgb_t   fg_reg, fg_next, bg_reg, bg_next;
    logic             rev_reg, rev_next;
    aecp_pkg::coord_t sav_x_reg, sav_x_next, sav_y_reg, sav_y_next;

    logic [7:0]       fin_reg, fin_next;
    aecp_pkg::coord_t cx_reg, cx_next, cy_reg, cy_next;
    aecp_pkg::param_t p0_reg, p0_next;
    logic [StepW-1:0] step_reg, step_next, hx_reg, hx_next, hy_reg, hy_next;

    logic             out_load, slot_free;
    aecp_pkg::action_t     o_act;
    aecp_pkg::erase_mode_t o_mode;
    logic [7:0]       o_glyph;
    aecp_pkg::coord_t o_x, o_y;

    logic                    m_valid_reg, m_valid_next;
    aecp_pkg::action_t       act_reg;
    logic [7:0]              glyph_reg;
    aecp_pkg::rgb_t          ofg_reg, obg_reg;
    logic                    orev_reg;
    aecp_pkg::coord_t        ox_reg, oy_reg;
    aecp_pkg::erase_mode_t   mode_reg;

    aecp_pkg::param_t p0_w, p1_w, sp;
    wide_t            sum_y, sum_x;

    assign slot_free = !m_valid_reg || m_ready;
    assign p0_w      = store_reg[0];
    assign p1_w      = (count_reg >= CntW'(2)) ? store_reg[1] : '0;
    assign sp        = store_reg[idx_reg];
    assign sum_y     = wide_t'(cy_reg) + wide_t'(step_reg);
    assign sum_x     = wide_t'(cx_reg) + wide_t'(step_reg);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        fg_next      = fg_reg;
        bg_next      = bg_reg;
        rev_next     = rev_reg;
        sav_x_next   = sav_x_reg;
        sav_y_next   = sav_y_reg;
        fin_next     = fin_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        p0_next      = p0_reg;
        step_next    = step_reg;
        hx_next      = hx_reg;
        hy_next      = hy_reg;
        pop          = 1'b0;
        store_we     = 1'b0;
        out_load     = 1'b0;
        o_act        = aecp_pkg::ACT_MOVE;
        o_glyph      = '0;
        o_x          = cx_reg;
        o_y          = cy_reg;
        o_mode       = aecp_pkg::EL_TO_END;

        unique case (state_reg)
            aecp_pkg::BK_IDLE: begin
                if (!empty && slot_free) begin
                    pop = 1'b1;
                    case (head.kind)
                        aecp_pkg::TOK_PLAIN: begin
                            out_load = 1'b1;
                            o_act    = aecp_pkg::ACT_DRAW;
                            o_glyph  = head.code;
                            o_x      = head.cx;
                            o_y      = head.cy;
                        end
                        aecp_pkg::TOK_SAVE: begin
                            sav_x_next = head.cx;
                            sav_y_next = head.cy;
                        end
                        aecp_pkg::TOK_RESTORE: begin
                            out_load = 1'b1;
                            o_x      = sav_x_reg;
                            o_y      = sav_y_reg;
                        end
                        aecp_pkg::TOK_PARAM, aecp_pkg::TOK_FINAL: begin
                            // parameters past the store depth are dropped
                            if (count_reg < CntW'(MAX_PARAMS)) begin
                                store_we   = 1'b1;
                                count_next = count_reg + CntW'(1);
                            end
                            if (head.kind == aecp_pkg::TOK_FINAL) begin
                                fin_next   = head.code;
                                cx_next    = head.cx;
                                cy_next    = head.cy;
                                state_next = aecp_pkg::BK_OPER;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            aecp_pkg::BK_OPER: begin
                p0_next   = p0_w;
                step_next = StepW'(p0_w) * StepW'(CELL_PIXELS);
                hx_next   = (p1_w != '0) ? StepW'(p1_w - 16'd1) * StepW'(CELL_PIXELS) : '0;
                hy_next   = (p0_w != '0) ? StepW'(p0_w - 16'd1) * StepW'(CELL_PIXELS) : '0;
                idx_next  = '0;
                state_next = (fin_reg == aecp_pkg::CharLowM) ? aecp_pkg::BK_SGR :
                                                               aecp_pkg::BK_RESULT;
            end
            aecp_pkg::BK_SGR: begin
                // one stored parameter per cycle
                if (sp == 16'd0) begin
                    fg_next  = aecp_pkg::RgbWhite;
                    bg_next  = aecp_pkg::RgbBlack;
                    rev_next = 1'b0;
                end else if (sp == 16'd7) begin
                    rev_next = 1'b1;
                end else if (sp == 16'd27) begin
                    rev_next = 1'b0;
                end else if (sp >= 16'd30 && sp <= 16'd37) begin
                    fg_next = aecp_pkg::palette_rgb({1'b0, 3'(sp - 16'd30)});
                end else if (sp >= 16'd40 && sp <= 16'd47) begin
                    bg_next = aecp_pkg::palette_rgb({1'b0, 3'(sp - 16'd40)});
                end else if (sp >= 16'd90 && sp <= 16'd97) begin
                    fg_next = aecp_pkg::palette_rgb({1'b1, 3'(sp - 16'd90)});
                end else if (sp >= 16'd100 && sp <= 16'd107) begin
                    bg_next = aecp_pkg::palette_rgb({1'b1, 3'(sp - 16'd100)});
                end
                if (CntW'(idx_reg) + CntW'(1) == count_reg) begin
                    count_next = '0;
                    state_next = aecp_pkg::BK_IDLE;
                end else begin
                    idx_next = idx_reg + IdxW'(1);
                end
            end
            aecp_pkg::BK_RESULT: begin
                if (slot_free) begin
                    count_next = '0;
                    state_next = aecp_pkg::BK_IDLE;
                    unique case (fin_reg) inside
                        aecp_pkg::CharUpH, aecp_pkg::CharLowF: begin
                            out_load = 1'b1;
                            o_x      = clamp_c(wide_t'(hx_reg));
                            o_y      = clamp_c(wide_t'(hy_reg));
                        end
                        aecp_pkg::CharUpA: begin
                            out_load = 1'b1;
                            o_y = (step_reg >= StepW'(cy_reg)) ? '0 :
                                  cy_reg - step_reg[aecp_pkg::CoordBits-1:0];
                        end
                        aecp_pkg::CharUpB: begin
                            out_load = 1'b1;
                            o_y      = clamp_c(sum_y);
                        end
                        aecp_pkg::CharUpC: begin
                            out_load = 1'b1;
                            o_x      = clamp_c(sum_x);
                        end
                        aecp_pkg::CharUpD: begin
                            out_load = 1'b1;
                            o_x = (step_reg >= StepW'(cx_reg)) ? '0 :
                                  cx_reg - step_reg[aecp_pkg::CoordBits-1:0];
                        end
                        aecp_pkg::CharUpJ: begin
                            if (p0_reg == 16'd0) begin
                                out_load = 1'b1;
                                o_act    = aecp_pkg::ACT_ERASE_BELOW;
                            end else if (p0_reg == 16'd2 || p0_reg == 16'd3) begin
                                out_load = 1'b1;
                                o_act    = aecp_pkg::ACT_CLEAR;
                            end
                        end
                        aecp_pkg::CharUpK: begin
                            out_load = 1'b1;
                            o_act    = aecp_pkg::ACT_ERASE_LINE;
                            if (p0_reg == 16'd1) begin
                                o_mode = aecp_pkg::EL_TO_START;
                            end else if (p0_reg == 16'd2) begin
                                o_mode = aecp_pkg::EL_WHOLE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        endcase

        m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_reg[count_reg[IdxW-1:0]] <= head.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            act_reg   <= o_act;
            glyph_reg <= o_glyph;
            ofg_reg   <= fg_reg;
            obg_reg   <= bg_reg;
            orev_reg  <= rev_reg;
            ox_reg    <= o_x;
            oy_reg    <= o_y;
            mode_reg  <= o_mode;
        end
        fin_reg  <= fin_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        p0_reg   <= p0_next;
        step_reg <= step_next;
        hx_reg   <= hx_next;
        hy_reg   <= hy_next;
        idx_reg  <= idx_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= aecp_pkg::BK_IDLE;
            count_reg   <= '0;
            fg_reg      <= aecp_pkg::RgbWhite;
            bg_reg      <= aecp_pkg::RgbBlack;
            rev_reg     <= 1'b0;
            sav_x_reg   <= '0;
            sav_y_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            fg_reg      <= fg_next;
            bg_reg      <= bg_next;
            rev_reg     <= rev_next;
            sav_x_reg   <= sav_x_next;
            sav_y_reg   <= sav_y_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_action     = act_reg;
    assign m_glyph_code = glyph_reg;
    assign m_fg_color   = ofg_reg;
    assign m_bg_color   = obg_reg;
    assign m_reverse_on = orev_reg;
    assign m_new_x      = ox_reg;
    assign m_new_y      = oy_reg;
    assign m_erase_mode = mode_reg;

endmodule

>>> hdl/aecp_checker.sv
module aecp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_action,
    input logic [7:0]  m_glyph_code,
    input logic [1:0]  m_erase_mode
);

    // a stalled request keeps its action and glyph
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_action) && $stable(m_glyph_code))
        else $error("output request changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_action_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_action <= aecp_pkg::ACT_ERASE_LINE)
        else $error("action code out of range");

    a_mode_only_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_action != aecp_pkg::ACT_ERASE_LINE |-> m_erase_mode == 2'd0)
        else $error("erase mode set on a non line-erase request");

    a_glyph_only_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_action != aecp_pkg::ACT_DRAW |-> m_glyph_code == 8'd0)
        else $error("glyph set on a non draw request");

endmodule

bind ansi_escape_console_parser_unit aecp_checker u_aecp_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_action     (m_action),
    .m_glyph_code (m_glyph_code),
    .m_erase_mode (m_erase_mode)
);
